[hdl/ttr_pkg.sv]
// ttr_pkg: shared types and constants of the triangle tile rasterizer.
// Used by ttr_alu and triangle_tile_rasterizer; depends on nothing.

package ttr_pkg;

	// Geometry and fixed point
	localparam int TILE_BITS    = 3;
	localparam int TILE_SIZE    = 1 << TILE_BITS;
	localparam int MAX_DIM      = 4096;
	localparam int UV_FRAC_BITS = 16;
	localparam int SUB_BITS     = 8;
	localparam int UV_SHIFT     = UV_FRAC_BITS - SUB_BITS;

	localparam int DIM_W   = 13;   // configuration register width
	localparam int UV_W    = 20;   // input UV width
	localparam int COORD_W = 27;   // subpixel vertex coordinate, holds +-2^25
	localparam int PIX_W   = 20;   // signed pixel index for bounding box math
	localparam int MUL_W   = 28;   // shared multiplier operand width
	localparam int ACC_W   = 64;   // accumulator width
	localparam int WGT_W   = 57;   // nonnegative edge weight and area width

	localparam logic signed [ACC_W-1:0] COORD_LIMIT = 64'sd33554432;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;

	// Shared unit operations
	typedef logic [2:0] alu_op_t;
	localparam alu_op_t OP_NOP     = 3'd0;
	localparam alu_op_t OP_MUL     = 3'd1;
	localparam alu_op_t OP_MULSUB  = 3'd2;
	localparam alu_op_t OP_MACCLR  = 3'd3;
	localparam alu_op_t OP_MAC     = 3'd4;
	localparam alu_op_t OP_RND     = 3'd5;
	localparam alu_op_t OP_DIVSTEP = 3'd6;

	typedef struct packed {
		alu_op_t                   op;
		logic signed [MUL_W-1:0]   a;
		logic signed [MUL_W-1:0]   b;
		logic        [7:0]         mac_c;
		logic        [WGT_W-1:0]   mac_w;
		logic        [WGT_W-1:0]   area;
	} alu_req_t;

endpackage

[hdl/triangle_tile_rasterizer.sv]
// triangle_tile_rasterizer: top level; sequencer, vertex and pixel registers.
// Depends on ttr_pkg and ttr_alu.
//
//  channel   | ports                                        | transfer when
//  ----------+----------------------------------------------+-------------------
//  config    | wr_en, wr_index, wr_data                     | wr_en high
//  triangle  | start, busy, vert*_u/v, color_a..c, tile_*   | start & !busy
//  pixel     | strobe, pixel_x/y, pixel_color, covered,     | strobe high
//            | painted_count, last                          |
//
// One triangle goes through vertex scaling, bounding box and area, then the
// edge functions at each tested pixel (the test stops at the first negative
// edge), a multiply-accumulate, round and divide per channel of each covered
// pixel and a final step; all multiplies and divide steps use the shared unit.
// Reset sets both texture dimensions to 1024 and the sequencer to idle.
// Results cannot be stalled; each is shown for exactly one cycle.

module triangle_tile_rasterizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [12:0]         wr_data,
	input  logic                start,
	output logic                busy,
	input  logic signed [19:0]  vert0_u,
	input  logic signed [19:0]  vert0_v,
	input  logic signed [19:0]  vert1_u,
	input  logic signed [19:0]  vert1_v,
	input  logic signed [19:0]  vert2_u,
	input  logic signed [19:0]  vert2_v,
	input  logic [31:0]         color_a,
	input  logic [31:0]         color_b,
	input  logic [31:0]         color_c,
	input  logic [8:0]          tile_col,
	input  logic [8:0]          tile_row,
	output logic                strobe,
	output logic [11:0]         pixel_x,
	output logic [11:0]         pixel_y,
	output logic [31:0]         pixel_color,
	output logic                covered,
	output logic [6:0]          painted_count,
	output logic                last
);

	localparam int CW = ttr_pkg::COORD_W;
	localparam int MW = ttr_pkg::MUL_W;
	localparam int PW = ttr_pkg::PIX_W;
	localparam int DW = ttr_pkg::DIM_W;
	localparam int AW = ttr_pkg::ACC_W;
	localparam int WW = ttr_pkg::WGT_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CONV  = 4'd1;
	localparam logic [3:0] S_CONVW = 4'd2;
	localparam logic [3:0] S_BBOX  = 4'd3;
	localparam logic [3:0] S_AREA0 = 4'd4;
	localparam logic [3:0] S_AREA1 = 4'd5;
	localparam logic [3:0] S_AREA2 = 4'd6;
	localparam logic [3:0] S_EDGE0 = 4'd7;
	localparam logic [3:0] S_EDGE1 = 4'd8;
	localparam logic [3:0] S_EDGE2 = 4'd9;
	localparam logic [3:0] S_MAC   = 4'd10;
	localparam logic [3:0] S_RND   = 4'd11;
	localparam logic [3:0] S_DIV   = 4'd12;
	localparam logic [3:0] S_CAP   = 4'd13;
	localparam logic [3:0] S_EMIT  = 4'd14;
	localparam logic [3:0] S_FIN   = 4'd15;

	function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] r);
		eff_dim = (r > DW'(ttr_pkg::MAX_DIM)) ? DW'(ttr_pkg::MAX_DIM) : r;
	endfunction

	// Control and storage
	logic [3:0]                  state_q;
	logic [2:0]                  cnt_q;
	logic [1:0]                  k_q;
	logic [1:0]                  ch_q;
	logic [DW-1:0]               tex_width_q, tex_height_q;
	logic [DW-1:0]               w_q, h_q;
	logic signed [19:0]          uv_q [6];
	logic [31:0]                 col_q [3];
	logic [8:0]                  tile_col_q, tile_row_q;
	logic signed [CW-1:0]        vx_q [3];
	logic signed [CW-1:0]        vy_q [3];
	logic [WW-1:0]               wgt_q [3];
	logic [WW-1:0]               area_q;
	logic                        flip_q;
	logic                        bb_empty_q;
	logic signed [PW-1:0]        bx0_q, bx1_q, by0_q, by1_q;
	logic signed [PW-1:0]        x_q, y_q;
	logic [31:0]                 col_acc_q;
	logic                        pend_v_q;
	logic [11:0]                 pend_x_q, pend_y_q;
	logic [31:0]                 pend_col_q;
	logic [6:0]                  count_q;
	logic                        strobe_q, covered_q, last_q;
	logic [11:0]                 pixel_x_q, pixel_y_q;
	logic [31:0]                 pixel_color_q;
	logic [6:0]                  painted_count_q;

	ttr_pkg::alu_req_t           req;
	logic signed [AW-1:0]        res;
	logic [7:0]                  quo;

	ttr_alu u_alu (
		.clk (clk),
		.req (req),
		.res (res),
		.quo (quo)
	);

	// Edge operand selection
	logic [1:0]              ea, eb, esel;
	logic signed [MW-1:0]    ax, ay, bx, by, cx, cy;
	logic signed [MW:0]      d1, d2, d3, d4;
	logic [4:0]              sh;
	logic [31:0]             csh;

	always_comb begin
		esel = (state_q == S_AREA0 || state_q == S_AREA1) ? 2'd2 : k_q;
		unique case (esel)
			2'd0:    begin ea = 2'd1; eb = 2'd2; end
			2'd1:    begin ea = 2'd2; eb = 2'd0; end
			default: begin ea = 2'd0; eb = 2'd1; end
		endcase
		ax = MW'(vx_q[ea]);
		ay = MW'(vy_q[ea]);
		bx = MW'(vx_q[eb]);
		by = MW'(vy_q[eb]);
		if (state_q == S_AREA0 || state_q == S_AREA1) begin
			cx = MW'(vx_q[2]);
			cy = MW'(vy_q[2]);
		end else begin
			cx = signed'({x_q, 8'h80});
			cy = signed'({y_q, 8'h80});
		end
		d1 = (MW+1)'(cx) - (MW+1)'(ax);
		d2 = (MW+1)'(by) - (MW+1)'(ay);
		d3 = (MW+1)'(cy) - (MW+1)'(ay);
		d4 = (MW+1)'(bx) - (MW+1)'(ax);
		sh  = 5'd24 - {ch_q, 3'b000};
		csh = col_q[cnt_q[1:0]] >> sh;
	end

	// Drive the shared unit
	always_comb begin
		req       = '0;
		req.mac_c = csh[7:0];
		req.mac_w = wgt_q[cnt_q[1:0]];
		req.area  = area_q;
		unique case (state_q)
			S_CONV: begin
				req.op = ttr_pkg::OP_MUL;
				req.a  = MW'(uv_q[cnt_q]);
				req.b  = signed'(MW'(cnt_q[0] ? h_q : w_q));
			end
			S_AREA0, S_EDGE0: begin
				req.op = ttr_pkg::OP_MUL;
				req.a  = d1[MW-1:0];
				req.b  = d2[MW-1:0];
			end
			S_AREA1, S_EDGE1: begin
				req.op = ttr_pkg::OP_MULSUB;
				req.a  = d3[MW-1:0];
				req.b  = d4[MW-1:0];
			end
			S_MAC:   req.op = (cnt_q == 3'd0) ? ttr_pkg::OP_MACCLR : ttr_pkg::OP_MAC;
			S_RND:   req.op = ttr_pkg::OP_RND;
			S_DIV:   req.op = ttr_pkg::OP_DIVSTEP;
			default: req.op = ttr_pkg::OP_NOP;
		endcase
	end

	// Vertex scaling, bounding box, edge weight and pixel stepping
	logic signed [AW-1:0]    conv_sh, conv_sat;
	logic signed [CW-1:0]    mnx, mxx, mny, mxy;
	logic signed [PW-1:0]    bx0r, bx1r, by0r, by1r, tx, ty;
	logic signed [PW-1:0]    bx0c, bx1c, by0c, by1c;
	logic signed [AW-1:0]    wv;
	logic                    x_end, y_end;

	always_comb begin
		conv_sh = res >>> ttr_pkg::UV_SHIFT;
		if (conv_sh > ttr_pkg::COORD_LIMIT)
			conv_sat = ttr_pkg::COORD_LIMIT;
		else if (conv_sh < -ttr_pkg::COORD_LIMIT)
			conv_sat = -ttr_pkg::COORD_LIMIT;
		else
			conv_sat = conv_sh;

		mnx = (vx_q[0] < vx_q[1]) ? vx_q[0] : vx_q[1];
		mnx = (mnx < vx_q[2]) ? mnx : vx_q[2];
		mxx = (vx_q[0] > vx_q[1]) ? vx_q[0] : vx_q[1];
		mxx = (mxx > vx_q[2]) ? mxx : vx_q[2];
		mny = (vy_q[0] < vy_q[1]) ? vy_q[0] : vy_q[1];
		mny = (mny < vy_q[2]) ? mny : vy_q[2];
		mxy = (vy_q[0] > vy_q[1]) ? vy_q[0] : vy_q[1];
		mxy = (mxy > vy_q[2]) ? mxy : vy_q[2];
		bx0r = PW'(mnx >>> ttr_pkg::SUB_BITS);
		by0r = PW'(mny >>> ttr_pkg::SUB_BITS);
		bx1r = PW'(((CW+1)'(mxx) + (CW+1)'(255)) >>> ttr_pkg::SUB_BITS);
		by1r = PW'(((CW+1)'(mxy) + (CW+1)'(255)) >>> ttr_pkg::SUB_BITS);
		tx = signed'(PW'({tile_col_q, {ttr_pkg::TILE_BITS{1'b0}}}));
		ty = signed'(PW'({tile_row_q, {ttr_pkg::TILE_BITS{1'b0}}}));

		// Clip to tile and texture
		bx0c = (bx0r > tx) ? bx0r : tx;
		by0c = (by0r > ty) ? by0r : ty;
		bx1c = (bx1r < signed'(PW'(w_q))) ? bx1r : signed'(PW'(w_q));
		bx1c = (bx1c < tx + PW'(ttr_pkg::TILE_SIZE)) ? bx1c : tx + PW'(ttr_pkg::TILE_SIZE);
		by1c = (by1r < signed'(PW'(h_q))) ? by1r : signed'(PW'(h_q));
		by1c = (by1c < ty + PW'(ttr_pkg::TILE_SIZE)) ? by1c : ty + PW'(ttr_pkg::TILE_SIZE);

		wv    = flip_q ? -res : res;
		x_end = (x_q + PW'(1)) >= bx1_q;
		y_end = (y_q + PW'(1)) >= by1_q;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= DW'(1024);
			tex_height_q <= DW'(1024);
		end else if (wr_en) begin
			unique case (wr_index)
				ttr_pkg::REG_TEX_WIDTH:  tex_width_q  <= wr_data;
				ttr_pkg::REG_TEX_HEIGHT: tex_height_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			k_q      <= '0;
			ch_q     <= '0;
			pend_v_q <= 1'b0;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						pend_v_q <= 1'b0;
						count_q  <= '0;
						cnt_q    <= '0;
						if (eff_dim(tex_width_q) == '0 || eff_dim(tex_height_q) == '0)
							state_q <= S_FIN;
						else
							state_q <= S_CONV;
					end
				end
				S_CONV: state_q <= S_CONVW;
				S_CONVW: begin
					if (cnt_q == 3'd5) begin
						state_q <= S_BBOX;
					end else begin
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_CONV;
					end
				end
				S_BBOX:  state_q <= S_AREA0;
				S_AREA0: state_q <= S_AREA1;
				S_AREA1: state_q <= S_AREA2;
				S_AREA2: begin
					k_q <= '0;
					if (res == '0 || bb_empty_q)
						state_q <= S_FIN;
					else
						state_q <= S_EDGE0;
				end
				S_EDGE0: state_q <= S_EDGE1;
				S_EDGE1: state_q <= S_EDGE2;
				S_EDGE2: begin
					if (wv < 0) begin
						k_q <= '0;
						state_q <= (x_end && y_end) ? S_FIN : S_EDGE0;
					end else if (k_q == 2'd2) begin
						ch_q    <= '0;
						cnt_q   <= '0;
						state_q <= S_MAC;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_EDGE0;
					end
				end
				S_MAC: begin
					if (cnt_q == 3'd2) begin
						cnt_q   <= '0;
						state_q <= S_RND;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_RND: state_q <= S_DIV;
				S_DIV: begin
					if (cnt_q == 3'd7) begin
						state_q <= S_CAP;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_CAP: begin
					cnt_q <= '0;
					if (ch_q == 2'd3) begin
						state_q <= S_EMIT;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= S_MAC;
					end
				end
				S_EMIT: begin
					// Release the previous pixel; hold this one until the next is known
					strobe_q <= pend_v_q;
					pend_v_q <= 1'b1;
					count_q  <= count_q + 7'd1;
					k_q      <= '0;
					state_q  <= (x_end && y_end) ? S_FIN : S_EDGE0;
				end
				S_FIN: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				uv_q[0]    <= vert0_u;
				uv_q[1]    <= vert0_v;
				uv_q[2]    <= vert1_u;
				uv_q[3]    <= vert1_v;
				uv_q[4]    <= vert2_u;
				uv_q[5]    <= vert2_v;
				col_q[0]   <= color_a;
				col_q[1]   <= color_b;
				col_q[2]   <= color_c;
				tile_col_q <= tile_col;
				tile_row_q <= tile_row;
				w_q        <= eff_dim(tex_width_q);
				h_q        <= eff_dim(tex_height_q);
			end
			S_CONVW: begin
				if (cnt_q[0])
					vy_q[cnt_q[2:1]] <= CW'(conv_sat);
				else
					vx_q[cnt_q[2:1]] <= CW'(conv_sat);
			end
			S_BBOX: begin
				bx0_q      <= bx0c;
				bx1_q      <= bx1c;
				by0_q      <= by0c;
				by1_q      <= by1c;
				bb_empty_q <= (bx0c >= bx1c) || (by0c >= by1c);
			end
			S_AREA2: begin
				flip_q <= res < 0;
				area_q <= WW'((res < 0) ? -res : res);
				x_q    <= bx0_q;
				y_q    <= by0_q;
			end
			S_EDGE2: begin
				if (wv >= 0)
					wgt_q[k_q] <= WW'(wv);
				else if (!x_end)
					x_q <= x_q + PW'(1);
				else if (!y_end) begin
					x_q <= bx0_q;
					y_q <= y_q + PW'(1);
				end
			end
			S_CAP: col_acc_q <= {col_acc_q[23:0], quo};
			S_EMIT: begin
				pixel_x_q       <= pend_x_q;
				pixel_y_q       <= pend_y_q;
				pixel_color_q   <= pend_col_q;
				covered_q       <= 1'b1;
				painted_count_q <= '0;
				last_q          <= 1'b0;
				pend_x_q        <= x_q[11:0];
				pend_y_q        <= y_q[11:0];
				pend_col_q      <= col_acc_q;
				if (!x_end)
					x_q <= x_q + PW'(1);
				else if (!y_end) begin
					x_q <= bx0_q;
					y_q <= y_q + PW'(1);
				end
			end
			S_FIN: begin
				last_q <= 1'b1;
				if (pend_v_q) begin
					pixel_x_q       <= pend_x_q;
					pixel_y_q       <= pend_y_q;
					pixel_color_q   <= pend_col_q;
					covered_q       <= 1'b1;
					painted_count_q <= count_q;
				end else begin
					pixel_x_q       <= '0;
					pixel_y_q       <= '0;
					pixel_color_q   <= '0;
					covered_q       <= 1'b0;
					painted_count_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign busy          = (state_q != S_IDLE);
	assign strobe        = strobe_q;
	assign pixel_x       = pixel_x_q;
	assign pixel_y       = pixel_y_q;
	assign pixel_color   = pixel_color_q;
	assign covered       = covered_q;
	assign painted_count = painted_count_q;
	assign last          = last_q;

`ifndef SYNTHESIS
	// Every result before the final one is a covered pixel with no count
	a_mid_covered: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> covered && painted_count == 7'd0)
		else $error("non-final result not a plain covered pixel");

	// The empty marker is always final and carries no count
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !covered |-> last && painted_count == 7'd0)
		else $error("empty marker malformed");

	// A final covered result reports at least one painted pixel
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last && covered |-> painted_count != 7'd0)
		else $error("final pixel with zero count");

	// An accepted triangle makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("start transfer did not raise busy");

	// The final result returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("final result while still busy");
`endif

endmodule

[hdl/ttr_alu.sv]
// ttr_alu: shared arithmetic unit of the rasterizer: signed multiply and
// multiply-subtract, color multiply-accumulate, rounding, and one restoring divide step.
// Depends on ttr_pkg.

module ttr_alu (
	input  logic                              clk,
	input  ttr_pkg::alu_req_t                 req,
	output logic signed [ttr_pkg::ACC_W-1:0]  res,
	output logic        [7:0]                 quo
);

	logic signed [2*ttr_pkg::MUL_W-1:0] prod;
	logic signed [ttr_pkg::ACC_W-1:0]   prod_ext;
	logic        [ttr_pkg::ACC_W:0]     macp;
	logic signed [ttr_pkg::ACC_W-1:0]   res_q;
	logic        [ttr_pkg::ACC_W-1:0]   dv_q;
	logic        [7:0]                  quo_q;

	// Form the products
	always_comb begin
		prod     = req.a * req.b;
		prod_ext = {{(ttr_pkg::ACC_W - 2*ttr_pkg::MUL_W){prod[2*ttr_pkg::MUL_W-1]}}, prod};
		macp     = (ttr_pkg::ACC_W+1)'(req.mac_c) * (ttr_pkg::ACC_W+1)'(req.mac_w);
	end

	// Accumulate, round and divide one quotient bit a cycle
	always_ff @(posedge clk) begin
		case (req.op)
			ttr_pkg::OP_MUL:    res_q <= prod_ext;
			ttr_pkg::OP_MULSUB: res_q <= res_q - prod_ext;
			ttr_pkg::OP_MACCLR: res_q <= signed'(macp[ttr_pkg::ACC_W-1:0]);
			ttr_pkg::OP_MAC:    res_q <= res_q + signed'(macp[ttr_pkg::ACC_W-1:0]);
			ttr_pkg::OP_RND: begin
				res_q <= res_q + signed'(ttr_pkg::ACC_W'(req.area >> 1));
				dv_q  <= ttr_pkg::ACC_W'(req.area) << 7;
				quo_q <= '0;
			end
			ttr_pkg::OP_DIVSTEP: begin
				if (unsigned'(res_q) >= dv_q) begin
					res_q <= res_q - signed'(dv_q);
					quo_q <= {quo_q[6:0], 1'b1};
				end else begin
					quo_q <= {quo_q[6:0], 1'b0};
				end
				dv_q <= dv_q >> 1;
			end
			default: ;
		endcase
	end

	assign res = res_q;
	assign quo = quo_q;

endmodule
